/* src/soa_pkg.sv */
// Shared types and constants for the shifting ordered array.
`default_nettype none

package soa_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int ADDR_BITS = $clog2(DEPTH);
	localparam int LEN_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADIDX = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                        kind;
		logic [LEN_BITS-1:0]          position;
		logic signed [WORD_BITS-1:0]  item_value;
	} req_t;

	typedef struct packed {
		status_t                      status;
		logic [LEN_BITS-1:0]          length_after;
		logic signed [WORD_BITS-1:0]  read_word;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic latch_status;
		logic wr_value;
		logic wr_shift;
		logic rd_pos;
		logic rd_shift;
		logic ptr_load;
		logic ptr_step;
		logic len_inc;
		logic len_dec;
		logic load_rsp;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  reject;
		logic  more;
	} dp_flags_t;

endpackage

`default_nettype wire

/* src/soa_dp.sv */
// Datapath: entry memory, length count, shift pointer and result register.
`default_nettype none

module soa_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  soa_pkg::req_t       req,
	input  soa_pkg::dp_cmd_t    cmd,
	output soa_pkg::dp_flags_t  flags,
	output soa_pkg::rsp_t       rsp
);
	import soa_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];

	kind_t                 kind_q;
	logic [LEN_BITS-1:0]   pos_q;
	logic [WORD_BITS-1:0]  val_q;
	logic [LEN_BITS-1:0]   length_q;
	logic [LEN_BITS-1:0]   ptr_q;
	logic [WORD_BITS-1:0]  rdata_q;
	status_t               status_q;
	rsp_t                  rsp_q;

	logic                  bad;
	logic                  full;
	logic [LEN_BITS-1:0]   src_ptr;
	logic [ADDR_BITS-1:0]  wr_addr;
	logic [WORD_BITS-1:0]  wr_data;
	logic                  wr_en;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  rd_en;
	status_t               status_d;

	always_comb begin
		unique case (kind_q)
			KIND_APPEND: bad = 1'b0;
			KIND_INSERT: bad = (pos_q > length_q);
			KIND_REMOVE: bad = (pos_q >= length_q);
			KIND_READ:   bad = (pos_q >= length_q);
		endcase
	end

	assign full = (length_q >= LEN_BITS'(DEPTH))
		&& (kind_q == KIND_APPEND || kind_q == KIND_INSERT);

	assign flags.kind   = kind_q;
	assign flags.reject = bad || full;
	assign flags.more   = (kind_q == KIND_INSERT) ? (ptr_q > pos_q)
		: ((ptr_q + LEN_BITS'(1)) < length_q);

	assign src_ptr = (kind_q == KIND_INSERT) ? (ptr_q - LEN_BITS'(1))
		: (ptr_q + LEN_BITS'(1));

	always_comb begin
		wr_en   = cmd.wr_shift || cmd.wr_value;
		wr_addr = ptr_q[ADDR_BITS-1:0];
		wr_data = rdata_q;
		if (cmd.wr_value) begin
			wr_data = val_q;
			wr_addr = (kind_q == KIND_APPEND) ? length_q[ADDR_BITS-1:0]
				: pos_q[ADDR_BITS-1:0];
		end
		rd_en   = cmd.rd_shift || cmd.rd_pos;
		rd_addr = cmd.rd_shift ? src_ptr[ADDR_BITS-1:0] : pos_q[ADDR_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_comb begin
		priority if (bad) begin
			status_d = STAT_BADIDX;
		end else if (full) begin
			status_d = STAT_FULL;
		end else begin
			status_d = STAT_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_APPEND;
		end else if (cmd.capture) begin
			kind_q <= req.kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q  <= req.position;
			val_q  <= WORD_BITS'(req.item_value);
		end
		if (cmd.latch_status) begin
			status_q <= status_d;
		end
		if (cmd.ptr_load) begin
			ptr_q <= (kind_q == KIND_INSERT) ? length_q : pos_q;
		end else if (cmd.ptr_step) begin
			ptr_q <= src_ptr;
		end
		if (cmd.load_rsp) begin
			rsp_q.status       <= status_q;
			rsp_q.length_after <= length_q;
			rsp_q.read_word    <= (kind_q == KIND_READ && status_q == STAT_DONE)
				? signed'(rdata_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cmd.len_inc) begin
			length_q <= length_q + LEN_BITS'(1);
		end else if (cmd.len_dec) begin
			length_q <= length_q - LEN_BITS'(1);
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* src/soa_ctrl.sv */
// Controller: request sequencing, shift loop and result handshake.
`default_nettype none

module soa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	input  soa_pkg::dp_flags_t  flags,
	output soa_pkg::dp_cmd_t    cmd
);
	import soa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.latch_status = 1'b1;
				if (flags.reject) begin
					state_d = ST_FINISH;
				end else begin
					unique case (flags.kind)
						KIND_APPEND: begin
							cmd.wr_value = 1'b1;
							cmd.len_inc  = 1'b1;
							state_d      = ST_FINISH;
						end
						KIND_INSERT, KIND_REMOVE: begin
							cmd.ptr_load = 1'b1;
							state_d      = ST_SHIFT_RD;
						end
						KIND_READ: begin
							cmd.rd_pos = 1'b1;
							state_d    = ST_FINISH;
						end
					endcase
				end
			end
			ST_SHIFT_RD: begin
				if (flags.more) begin
					cmd.rd_shift = 1'b1;
					state_d      = ST_SHIFT_WR;
				end else begin
					if (flags.kind == KIND_INSERT) begin
						cmd.wr_value = 1'b1;
						cmd.len_inc  = 1'b1;
					end else begin
						cmd.len_dec = 1'b1;
					end
					state_d = ST_FINISH;
				end
			end
			ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_step = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* src/shifting_ordered_array.sv */
// Top level of the shifting ordered array.
//
// Holds an ordered list of up to DEPTH signed words in a single-port-style
// memory plus a length count. The req channel takes one request word
// (append, insert, remove or read) when req_valid is high and req_stall low;
// the rsp channel returns one result word per request: status, length after
// the request and the read word.
// A request is taken only while the controller is idle. Append, read and
// every rejected request pass from acceptance through the evaluate and
// finish states. Insert and remove move entries one at a time through the
// memory's read/write port, with a read state and a write state per moved
// entry; the number of entries shifted is length - position for insert
// and length - position - 1 for remove.
// Reset clears the length count and the controller; entry contents are
// left as they are, since only written entries can ever be read.
// The result sits in an output register: a stalled receiver holds it
// there, the next request is still taken and worked on, and its result
// waits in the controller until the register is free.
`default_nettype none

module shifting_ordered_array (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  soa_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output soa_pkg::rsp_t  rsp
);
	import soa_pkg::*;

	dp_cmd_t   cmd;
	dp_flags_t flags;

	soa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	soa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.flags  (flags),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
